// ----- rtl/arpc_pkg.sv -----
// Package for the ARP responder with sender cache.
// Holds cache sizing, protocol codes, verdict codes and controller/datapath structs.
// No dependencies.
package arpc_pkg;

    // Cache sizing.
    localparam int CACHE_ENTRIES = 16;
    localparam int IDX_W = (CACHE_ENTRIES > 1) ? $clog2(CACHE_ENTRIES) : 1;

    // Protocol field codes.
    localparam logic [15:0] HW_ETHERNET = 16'h0001;
    localparam logic [15:0] PROTO_IPV4  = 16'h0800;
    localparam logic [15:0] OP_REQUEST  = 16'h0001;
    localparam logic [15:0] OP_REPLY    = 16'h0002;

    // Configuration register indexes.
    localparam int CFG_IDX_W = 8;
    localparam logic [CFG_IDX_W-1:0] REG_OWN_IP  = 8'd0;
    localparam logic [CFG_IDX_W-1:0] REG_OWN_MAC = 8'd1;

    // Stream payload widths.
    localparam int IN_DATA_W  = 160;
    localparam int OUT_DATA_W = 184;

    // Result verdicts.
    typedef enum logic [2:0] {
        VERDICT_REPLIED     = 3'd0,
        VERDICT_BAD_HW      = 3'd1,
        VERDICT_BAD_PROTO   = 3'd2,
        VERDICT_NOT_US      = 3'd3,
        VERDICT_BAD_OPCODE  = 3'd4
    } verdict_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;     // capture an incoming packet and clear the scan state
        logic step;     // examine one cache entry
        logic finish;   // update the cache and load the result register
    } cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic in_ok;      // hardware and protocol types are supported
        logic scan_last;  // the entry under the scan counter is the last one
        logic out_free;   // the result register can take a new result
    } status_t;

endpackage

// ----- rtl/arpc_ctrl.sv -----
// Controller of the ARP responder: sequences capture, cache scan and finish.
// Depends on arpc_pkg.
module arpc_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  arpc_pkg::status_t status,
    output arpc_pkg::cmd_t    cmd
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_FINISH
    } state_t;

    state_t state_reg;
    state_t state_next;

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (!status.in_ok || status.scan_last)
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                if (status.out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Commands follow combinationally from the state, in_valid and the status.
    always_comb
    begin
        in_ready   = (state_reg == ST_IDLE);
        cmd.load   = (state_reg == ST_IDLE) && in_valid;
        cmd.step   = (state_reg == ST_SCAN) && status.in_ok;
        cmd.finish = (state_reg == ST_FINISH) && status.out_free;
    end

    // State register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

// ----- rtl/arpc_datapath.sv -----
// Datapath of the ARP responder: packet registers, configuration registers,
// the sender cache with its scan logic, and the result register.
// Depends on arpc_pkg.
module arpc_datapath (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic [arpc_pkg::IN_DATA_W-1:0]      in_data,
    input  logic                                cfg_write,
    input  logic [arpc_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [47:0]                         cfg_data,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic [arpc_pkg::OUT_DATA_W-1:0]     out_data,
    input  arpc_pkg::cmd_t                      cmd,
    output arpc_pkg::status_t                   status
);

    localparam int IW = arpc_pkg::IDX_W;
    localparam int N  = arpc_pkg::CACHE_ENTRIES;

    // Captured packet fields.
    logic [15:0] hw_type_reg;
    logic [15:0] proto_type_reg;
    logic [15:0] arp_opcode_reg;
    logic [47:0] sender_mac_reg;
    logic [31:0] sender_ip_reg;
    logic [31:0] target_ip_reg;

    // Configuration.
    logic [31:0] own_ip_reg;
    logic [47:0] own_mac_reg;

    // Cache: a used bit per entry and the sender IP. Every stored entry
    // carries the Ethernet hardware type, so the IP alone decides a match.
    logic [N-1:0] used_reg;
    logic [31:0]  ip_mem [N];

    // Scan state.
    logic [IW-1:0] cnt_reg;
    logic          hit_reg;
    logic          free_found_reg;
    logic [IW-1:0] free_idx_reg;

    // Result register.
    logic                                out_valid_reg;
    logic [arpc_pkg::OUT_DATA_W-1:0]     out_data_reg;

    logic       for_us;
    logic       do_insert;
    logic       full;
    logic       refreshed;
    logic       reply;
    arpc_pkg::verdict_t verdict;

    // Status toward the controller.
    always_comb
    begin
        status.in_ok     = (hw_type_reg == arpc_pkg::HW_ETHERNET)
                        && (proto_type_reg == arpc_pkg::PROTO_IPV4);
        status.scan_last = (cnt_reg == IW'(N - 1));
        status.out_free  = !out_valid_reg || out_ready;
    end

    // Outcome of a packet once the scan has finished.
    always_comb
    begin
        for_us    = (target_ip_reg == own_ip_reg);
        refreshed = status.in_ok && hit_reg;
        do_insert = status.in_ok && for_us && !hit_reg && free_found_reg;
        full      = status.in_ok && for_us && !hit_reg && !free_found_reg;
        reply     = 1'b0;
        if (hw_type_reg != arpc_pkg::HW_ETHERNET)
        begin
            verdict = arpc_pkg::VERDICT_BAD_HW;
        end
        else if (proto_type_reg != arpc_pkg::PROTO_IPV4)
        begin
            verdict = arpc_pkg::VERDICT_BAD_PROTO;
        end
        else if (!for_us)
        begin
            verdict = arpc_pkg::VERDICT_NOT_US;
        end
        else if (arp_opcode_reg == arpc_pkg::OP_REQUEST)
        begin
            verdict = arpc_pkg::VERDICT_REPLIED;
            reply   = 1'b1;
        end
        else
        begin
            verdict = arpc_pkg::VERDICT_BAD_OPCODE;
        end
    end

    // Packet capture.
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            hw_type_reg    <= in_data[15:0];
            proto_type_reg <= in_data[31:16];
            arp_opcode_reg <= in_data[47:32];
            sender_mac_reg <= in_data[95:48];
            sender_ip_reg  <= in_data[127:96];
            target_ip_reg  <= in_data[159:128];
        end
    end

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            own_ip_reg  <= '0;
            own_mac_reg <= '0;
        end
        else if (cfg_write)
        begin
            if (cfg_index == arpc_pkg::REG_OWN_IP)
            begin
                own_ip_reg <= cfg_data[31:0];
            end
            else if (cfg_index == arpc_pkg::REG_OWN_MAC)
            begin
                own_mac_reg <= cfg_data;
            end
        end
    end

    // Scan one entry per cycle, remembering a match and the lowest free entry.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg        <= '0;
            hit_reg        <= 1'b0;
            free_found_reg <= 1'b0;
            free_idx_reg   <= '0;
        end
        else if (cmd.load)
        begin
            cnt_reg        <= '0;
            hit_reg        <= 1'b0;
            free_found_reg <= 1'b0;
        end
        else if (cmd.step)
        begin
            cnt_reg <= cnt_reg + IW'(1);
            if (used_reg[cnt_reg] && (ip_mem[cnt_reg] == sender_ip_reg))
            begin
                hit_reg <= 1'b1;
            end
            if (!used_reg[cnt_reg] && !free_found_reg)
            begin
                free_found_reg <= 1'b1;
                free_idx_reg   <= cnt_reg;
            end
        end
    end

    // Used bits clear at reset; a new sender claims the lowest free entry.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            used_reg <= '0;
        end
        else if (cmd.finish && do_insert)
        begin
            used_reg[free_idx_reg] <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.finish && do_insert)
        begin
            ip_mem[free_idx_reg] <= sender_ip_reg;
        end
    end

    // Result register valid flag.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.finish)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // Result payload; reply fields are zero unless a reply is sent.
    always_ff @(posedge clk)
    begin
        if (cmd.finish)
        begin
            out_data_reg[2:0]     <= verdict;
            out_data_reg[3]       <= refreshed;
            out_data_reg[4]       <= full;
            out_data_reg[5]       <= reply;
            out_data_reg[53:6]    <= reply ? sender_mac_reg : 48'd0;
            out_data_reg[85:54]   <= reply ? sender_ip_reg : 32'd0;
            out_data_reg[133:86]  <= reply ? own_mac_reg : 48'd0;
            out_data_reg[165:134] <= reply ? own_ip_reg : 32'd0;
            out_data_reg[181:166] <= reply ? arpc_pkg::OP_REPLY : 16'd0;
            out_data_reg[183:182] <= 2'b00;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

// ----- rtl/arp_request_responder_with_cache_core.sv -----
// Top level of the ARP responder with sender cache.
// Instantiates arpc_ctrl and arpc_datapath; depends on arpc_pkg.
//
// Usage:
// The slave stream carries the parsed fields of one received ARP packet per
// transaction. The master stream returns exactly one result per packet: a
// verdict, cache flags and, for a request addressed to this device, the
// reply fields with opcode 2. The configuration channel writes own_ip
// (index 0) and own_mac (index 1); other indexes are ignored. It is always
// ready; the user must write it only while no packet is in flight, and the
// block itself does not enforce this. Timing: a packet is taken in the idle
// state, then the cache is scanned one entry per cycle (every entry for
// valid types, none for bad types), and the finish state writes the result
// register as soon as it is free. Reset clears the configuration, every
// cache entry's used bit and the valid flag of the result register; the
// block is ready right after reset. When the receiver stalls, a finished
// result waits in the output register; the next packet is still accepted
// and scanned, and its result waits until the slot frees.
module arp_request_responder_with_cache_core (
    input  logic                                clk,
    input  logic                                rst_n,
    // Input packet transaction.
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    // tdata from bit 0: hw_type[15:0], proto_type[15:0], arp_opcode[15:0],
    // sender_mac[47:0], sender_ip[31:0], target_ip[31:0].
    input  logic [arpc_pkg::IN_DATA_W-1:0]      s_axis_tdata,
    // Result transaction.
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // tdata from bit 0: verdict[2:0], cache_refreshed, table_full, send_reply,
    // reply_dst_mac[47:0], reply_dst_ip[31:0], reply_src_mac[47:0],
    // reply_src_ip[31:0], reply_opcode[15:0], two zero pad bits.
    output logic [arpc_pkg::OUT_DATA_W-1:0]     m_axis_tdata,
    // Configuration write channel.
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [arpc_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [47:0]                         cfg_data
);

    arpc_pkg::cmd_t    cmd;
    arpc_pkg::status_t status;

    assign cfg_ready = 1'b1;

    // Sequencing of capture, scan and finish.
    arpc_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .status   (status),
        .cmd      (cmd)
    );

    // Registers, cache and result register.
    arpc_datapath u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_data   (s_axis_tdata),
        .cfg_write (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_data  (m_axis_tdata),
        .cmd       (cmd),
        .status    (status)
    );

endmodule
